[design/e2r_pkg.sv]
// Package: widths, CORDIC constants and helpers for the Euler-to-rotation-matrix block.
package e2r_pkg;
    localparam int CORDIC_STEPS    = 16;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int IN_W   = 18;
    localparam int OUT_W  = 16;
    localparam int ZQ     = 24;
    localparam int XQ     = 30;
    localparam int Z_W    = 36;
    localparam int X_W    = 34;
    localparam logic signed [X_W-1:0] CORDIC_GAIN = X_W'(652032874);
    localparam logic signed [X_W-1:0] ONE_Q30 = X_W'(64'sd1 << XQ);
    localparam logic signed [Z_W-1:0] FULL    = Z_W'(64'sd360 << ZQ);
    localparam logic signed [Z_W-1:0] HALF    = Z_W'(64'sd180 << ZQ);
    localparam logic signed [Z_W-1:0] QUARTER = Z_W'(64'sd90 << ZQ);
    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

    typedef logic signed [X_W-1:0] t_x;
    typedef logic signed [Z_W-1:0] t_z;

    typedef struct packed {
        t_x x;
        t_x y;
        t_z z;
        logic neg;
    } t_rot;

    typedef struct packed {
        t_rot p;
        t_rot w;
        t_rot r;
    } t_trip;

    function automatic t_z atan_step(input int i);
        logic signed [63:0] v;
        unique case (i)
            0: v = 64'sd754974720;
            1: v = 64'sd445687602;
            2: v = 64'sd235489089;
            3: v = 64'sd119537938;
            4: v = 64'sd60000934;
            5: v = 64'sd30029717;
            6: v = 64'sd15018523;
            7: v = 64'sd7509720;
            8: v = 64'sd3754917;
            9: v = 64'sd1877466;
            default: v = (64'sd961263669 + (64'sd1 << (i - 1))) >>> i;
        endcase
        return Z_W'(v);
    endfunction

    function automatic t_x clamp_unit(input t_x v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [35:0] v);
        logic signed [35:0] r;
        logic signed [35:0] lim;
        lim = 36'sd1 <<< OUT_FRAC_BITS;
        r = (v + (36'sd1 <<< (XQ - OUT_FRAC_BITS - 1))) >>> (XQ - OUT_FRAC_BITS);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[OUT_W-1:0];
    endfunction

    function automatic t_x mulq(input t_x a, input t_x b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + (68'sd1 <<< (XQ - 1));
        return X_W'(p >>> XQ);
    endfunction
endpackage

[design/e2r_cell.sv]
// One CORDIC cell: a fixed rotation step for three angles, with its valid/ready stage.
module e2r_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [e2r_pkg::STEP_W-1:0]  i_step,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  e2r_pkg::t_trip              i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output e2r_pkg::t_trip              o_data
);
    import e2r_pkg::*;

    logic  r_valid;
    t_trip r_data;
    t_trip n_data;

    function automatic t_rot rot(input t_rot a, input int s);
        t_rot b;
        t_z at;
        b = a;
        at = atan_step(s);
        if (!a.z[Z_W-1]) begin
            b.x = a.x - (a.y >>> s);
            b.y = a.y + (a.x >>> s);
            b.z = a.z - at;
        end else begin
            b.x = a.x + (a.y >>> s);
            b.y = a.y - (a.x >>> s);
            b.z = a.z + at;
        end
        return b;
    endfunction

    always_comb begin
        n_data.p = rot(i_data.p, int'(i_step));
        n_data.w = rot(i_data.w, int'(i_step));
        n_data.r = rot(i_data.r, int'(i_step));
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

[design/euler_to_rotation_matrix.sv]
// Top level: angle reduction, a chain of CORDIC cells and the matrix product stages.
// Usage:
//   Input channel i_valid/o_ready carries pitch, yaw and roll in degrees,
//   signed with 8 fraction bits; any 18-bit pattern is reduced modulo 360.
//   Output channel o_valid/i_ready carries the nine Q1.14 matrix entries.
//   Every stage is a register with its own valid bit and a ready that
//   passes back along the chain, so one item enters per cycle while the
//   receiver takes them.
//   Stages: 1 reduction stage, 16 CORDIC cells (one per step), 1 clamp
//   stage, 2 product stages and 1 output stage.
//   Throughput: one item per cycle while the receiver is ready, set by the chain of single-step cells.
//   When the receiver stalls, ready backs up stage by stage; items in
//   flight hold and none is lost.
//   Reset (synchronous, active low) clears all valid bits; the data
//   registers are not reset.
module euler_to_rotation_matrix (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [17:0]       i_pitch_deg,
    input  logic signed [17:0]       i_yaw_deg,
    input  logic signed [17:0]       i_roll_deg,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [15:0]       o_r00,
    output logic signed [15:0]       o_r10,
    output logic signed [15:0]       o_r20,
    output logic signed [15:0]       o_r01,
    output logic signed [15:0]       o_r11,
    output logic signed [15:0]       o_r21,
    output logic signed [15:0]       o_r02,
    output logic signed [15:0]       o_r12,
    output logic signed [15:0]       o_r22
);
    import e2r_pkg::*;

    function automatic t_rot reduce(input logic signed [IN_W-1:0] a);
        t_rot o;
        logic signed [Z_W-1:0] z;
        logic signed [Z_W-1:0] m;
        // a*2^16 lies within +-2^33, under two turns; fold into [0,360) by compares
        z = Z_W'(a) <<< (ZQ - ANGLE_FRAC_BITS);
        m = z;
        for (int k = 0; k < 2; k++) begin
            if (m < 0) m = m + (FULL <<< (1 - k));
        end
        for (int k = 0; k < 2; k++) begin
            if (m >= (FULL <<< (1 - k))) m = m - (FULL <<< (1 - k));
        end
        if (m > HALF) m = m - FULL;
        o.neg = 1'b0;
        if (m > QUARTER) begin
            m = m - HALF;
            o.neg = 1'b1;
        end else if (m < -QUARTER) begin
            m = m + HALF;
            o.neg = 1'b1;
        end
        o.x = CORDIC_GAIN;
        o.y = '0;
        o.z = m;
        return o;
    endfunction

    // stage 0: reduction
    logic  r_v0;
    t_trip r_d0;
    logic  rdy0;
    assign o_ready = !r_v0 || rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (o_ready) r_v0 <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_d0.p <= reduce(i_pitch_deg);
            r_d0.w <= reduce(i_yaw_deg);
            r_d0.r <= reduce(i_roll_deg);
        end
    end

    logic  c_v   [CORDIC_STEPS+1];
    logic  c_rdy [CORDIC_STEPS+1];
    t_trip c_d   [CORDIC_STEPS+1];
    assign c_v[0] = r_v0;
    assign c_d[0] = r_d0;
    assign rdy0   = c_rdy[0];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        e2r_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(g)),
            .i_valid (c_v[g]),
            .o_ready (c_rdy[g]),
            .i_data  (c_d[g]),
            .o_valid (c_v[g+1]),
            .i_ready (c_rdy[g+1]),
            .o_data  (c_d[g+1])
        );
    end

    // stage A: sign fix and clamp
    logic r_va, r_vb, r_vc, r_vo;
    logic rdy_a, rdy_b, rdy_c, rdy_o;
    t_x r_sp, r_cp, r_sy, r_cy, r_sr, r_cr;
    t_x r_crcy, r_crsy, r_srcy, r_srsy, r_cpcy, r_cpsy, r_srcp, r_crcp;
    t_x r_sp1;
    t_x r_t01, r_t11, r_t02, r_t12;
    t_x r_cpcy2, r_cpsy2, r_srcp2, r_crcp2, r_sp2;
    logic signed [OUT_W-1:0] r_o [9];

    assign rdy_o = !r_vo || i_ready;
    assign rdy_c = !r_vc || rdy_o;
    assign rdy_b = !r_vb || rdy_c;
    assign rdy_a = !r_va || rdy_b;
    assign c_rdy[CORDIC_STEPS] = rdy_a;

    function automatic t_x fix(input t_x v, input logic n);
        return clamp_unit(n ? -v : v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy_a) r_va <= c_v[CORDIC_STEPS];
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
            if (rdy_o) r_vo <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && c_v[CORDIC_STEPS]) begin
            r_sp <= fix(c_d[CORDIC_STEPS].p.y, c_d[CORDIC_STEPS].p.neg);
            r_cp <= fix(c_d[CORDIC_STEPS].p.x, c_d[CORDIC_STEPS].p.neg);
            r_sy <= fix(c_d[CORDIC_STEPS].w.y, c_d[CORDIC_STEPS].w.neg);
            r_cy <= fix(c_d[CORDIC_STEPS].w.x, c_d[CORDIC_STEPS].w.neg);
            r_sr <= fix(c_d[CORDIC_STEPS].r.y, c_d[CORDIC_STEPS].r.neg);
            r_cr <= fix(c_d[CORDIC_STEPS].r.x, c_d[CORDIC_STEPS].r.neg);
        end
        if (rdy_b && r_va) begin
            r_crcy <= mulq(r_cr, r_cy);
            r_crsy <= mulq(r_cr, r_sy);
            r_srcy <= mulq(r_sr, r_cy);
            r_srsy <= mulq(r_sr, r_sy);
            r_cpcy <= mulq(r_cp, r_cy);
            r_cpsy <= mulq(r_cp, r_sy);
            r_srcp <= mulq(r_sr, r_cp);
            r_crcp <= mulq(r_cr, r_cp);
            r_sp1  <= r_sp;
        end
        if (rdy_c && r_vb) begin
            r_t01 <= mulq(r_sp1, r_srcy) - r_crsy;
            r_t11 <= mulq(r_sp1, r_srsy) + r_crcy;
            r_t02 <= mulq(r_sp1, r_crcy) + r_srsy;
            r_t12 <= mulq(r_sp1, r_crsy) - r_srcy;
            // pass-through products move along with the item
            r_cpcy2 <= r_cpcy;
            r_cpsy2 <= r_cpsy;
            r_srcp2 <= r_srcp;
            r_crcp2 <= r_crcp;
            r_sp2   <= r_sp1;
        end
        if (rdy_o && r_vc) begin
            r_o[0] <= to_out(36'(r_cpcy2));
            r_o[1] <= to_out(36'(r_cpsy2));
            r_o[2] <= to_out(-36'(r_sp2));
            r_o[3] <= to_out(36'(r_t01));
            r_o[4] <= to_out(36'(r_t11));
            r_o[5] <= to_out(36'(r_srcp2));
            r_o[6] <= to_out(36'(r_t02));
            r_o[7] <= to_out(36'(r_t12));
            r_o[8] <= to_out(36'(r_crcp2));
        end
    end

    assign o_valid = r_vo;
    assign o_r00 = r_o[0];
    assign o_r10 = r_o[1];
    assign o_r20 = r_o[2];
    assign o_r01 = r_o[3];
    assign o_r11 = r_o[4];
    assign o_r21 = r_o[5];
    assign o_r02 = r_o[6];
    assign o_r12 = r_o[7];
    assign o_r22 = r_o[8];
endmodule
